### design/q24a_pkg.sv
// ----------------------------------------------------------------------------
// q24a_pkg
// Opcode and status codes of the signed fixed-point ALU.
// ----------------------------------------------------------------------------
`default_nettype none

package q24a_pkg;

	typedef enum logic [3:0] {
		OP_ADD      = 4'd0,
		OP_SUB      = 4'd1,
		OP_MUL      = 4'd2,
		OP_DIV      = 4'd3,
		OP_GT       = 4'd4,
		OP_LT       = 4'd5,
		OP_GE       = 4'd6,
		OP_LE       = 4'd7,
		OP_EQ       = 4'd8,
		OP_NE       = 4'd9,
		OP_MIN      = 4'd10,
		OP_MAX      = 4'd11,
		OP_INC      = 4'd12,
		OP_DEC      = 4'd13,
		OP_FROM_INT = 4'd14,
		OP_TO_INT   = 4'd15
	} op_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_OVF  = 2'd1,
		ST_DIVZ = 2'd2
	} status_t;

endpackage

`default_nettype wire

### design/q24a_div_step.sv
// ----------------------------------------------------------------------------
// q24a_div_step
// One restoring division step: shift in a numerator bit, trial subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module q24a_div_step #(
	parameter int W  = 32,
	parameter int NW = 41
) (
	input  logic [W-1:0]  rem,
	input  logic [W-1:0]  divisor,
	input  logic [NW-1:0] num,
	output logic [W-1:0]  rem_next,
	output logic [NW-1:0] num_next
);

	logic [W:0] trial;
	logic [W:0] diff;
	logic       fits;

	always_comb begin
		trial    = {rem, num[NW-1]};
		diff     = trial - {1'b0, divisor};
		fits     = (trial >= {1'b0, divisor});
		rem_next = fits ? diff[W-1:0] : trial[W-1:0];
		num_next = {num[NW-2:0], fits};
	end

endmodule

`default_nettype wire

### design/q24_8_fixed_point_alu_top.sv
// ----------------------------------------------------------------------------
// q24_8_fixed_point_alu_top
// Pipelined signed fixed-point ALU, Q(WORD_WIDTH-FRAC_BITS).FRAC_BITS.
// ----------------------------------------------------------------------------
// Accepts one transaction per cycle while the output is not stalled; every
// opcode passes through the same stages. Most of the depth is in the divider:
// one restoring step per quotient bit, WORD_WIDTH + FRAC_BITS + 1 steps,
// each in a pipeline stage of its own; the multiplier uses split partial
// products over four stages ahead of it.
// A stall on the output holds the whole pipeline and is passed to the input.
`default_nettype none

module q24_8_fixed_point_alu_top
	import q24a_pkg::*;
#(
	parameter int WORD_WIDTH = 32,
	parameter int FRAC_BITS  = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [3:0]                   op,
	input  logic signed [WORD_WIDTH-1:0] lhs,
	input  logic signed [WORD_WIDTH-1:0] rhs,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [WORD_WIDTH-1:0] result,
	output logic                         compare_true,
	output logic [1:0]                   status
);

	localparam int W  = WORD_WIDTH;
	localparam int F  = FRAC_BITS;
	localparam int NW = W + F + 1;
	localparam int H  = (W + 1) / 2;
	localparam int PW = 2 * W;

	localparam logic [W-1:0]  MAXW = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0]  MINW = {1'b1, {(W-1){1'b0}}};
	localparam logic [PW-1:0] HALF = (PW'(1) << F) >> 1;

	logic advance;

	// stage 1: decode and simple operations
	logic signed [W-1:0] sum, dif, incv, decv, fixv, backv, intv;
	logic                lt, gt, eq;
	logic [W-1:0]        res_c, ma_c, mb_c;
	logic                cmp_c;
	status_t             st_c;

	always_comb begin
		sum   = lhs + rhs;
		dif   = lhs - rhs;
		incv  = lhs + W'(1);
		decv  = lhs - W'(1);
		fixv  = lhs <<< F;
		backv = fixv >>> F;
		intv  = lhs >>> F;
		lt    = lhs < rhs;
		gt    = rhs < lhs;
		eq    = lhs == rhs;
		ma_c  = lhs[W-1] ? (~lhs + 1'b1) : lhs;
		mb_c  = rhs[W-1] ? (~rhs + 1'b1) : rhs;
		res_c = '0;
		cmp_c = 1'b0;
		st_c  = ST_OK;
		unique case (op_t'(op))
			OP_ADD: begin
				res_c = sum;
				if (((lhs[W-1] ^ sum[W-1]) & (rhs[W-1] ^ sum[W-1])) != 1'b0) st_c = ST_OVF;
			end
			OP_SUB: begin
				res_c = dif;
				if (((lhs[W-1] ^ rhs[W-1]) & (lhs[W-1] ^ dif[W-1])) != 1'b0) st_c = ST_OVF;
			end
			OP_MUL, OP_DIV: begin
				res_c = '0;
			end
			OP_GT: cmp_c = gt;
			OP_LT: cmp_c = lt;
			OP_GE: cmp_c = !lt;
			OP_LE: cmp_c = !gt;
			OP_EQ: cmp_c = eq;
			OP_NE: cmp_c = !eq;
			OP_MIN: res_c = lt ? lhs : rhs;
			OP_MAX: res_c = gt ? lhs : rhs;
			OP_INC: begin
				res_c = incv;
				if (lhs == MAXW) st_c = ST_OVF;
			end
			OP_DEC: begin
				res_c = decv;
				if (lhs == MINW) st_c = ST_OVF;
			end
			OP_FROM_INT: begin
				res_c = fixv;
				if (backv != lhs) st_c = ST_OVF;
			end
			OP_TO_INT: res_c = intv;
		endcase
	end

	logic         v_s1, v_s2, v_s3, v_s4;
	op_t          op_s1, op_s2, op_s3, op_s4;
	logic [W-1:0] res_s1, res_s2, res_s3, res_s4;
	logic         cmp_s1, cmp_s2, cmp_s3, cmp_s4;
	status_t      st_s1, st_s2, st_s3, st_s4;
	logic         neg_s1, neg_s2, neg_s3, neg_s4;
	logic         dz_s1, dz_s2, dz_s3, dz_s4;
	logic [W-1:0] ma_s1, ma_s2, ma_s3, ma_s4;
	logic [W-1:0] mb_s1, mb_s2, mb_s3, mb_s4;

	logic [2*H-1:0] ma_x, mb_x;
	logic [2*H-1:0] pp_hh_s2, pp_hl_s2, pp_lh_s2, pp_ll_s2;
	logic [4*H-1:0] psum;
	logic [PW-1:0]  prod_s3, pr_s4;

	assign ma_x = (2*H)'(ma_s1);
	assign mb_x = (2*H)'(mb_s1);
	assign psum = {pp_hh_s2, {(2*H){1'b0}}}
	            + {{H{1'b0}}, pp_hl_s2, {H{1'b0}}}
	            + {{H{1'b0}}, pp_lh_s2, {H{1'b0}}}
	            + {{(2*H){1'b0}}, pp_ll_s2};

	// mul saturation
	logic          mneg, movf;
	logic [PW-1:0] mlim;
	logic [W-1:0]  mres, mneg_v;

	always_comb begin
		mneg   = neg_s4 && (pr_s4 != '0);
		mlim   = PW'(mneg ? MINW : MAXW);
		movf   = pr_s4 > mlim;
		mneg_v = ~pr_s4[W-1:0] + 1'b1;
		if (movf) begin
			mres = mneg ? MINW : MAXW;
		end else begin
			mres = mneg ? mneg_v : pr_s4[W-1:0];
		end
	end

	// divider chain, index 0 is stage 5
	logic          v_sd   [NW+1];
	op_t           op_sd  [NW+1];
	logic [W-1:0]  res_sd [NW+1];
	logic          cmp_sd [NW+1];
	status_t       st_sd  [NW+1];
	logic          neg_sd [NW+1];
	logic          dz_sd  [NW+1];
	logic [W-1:0]  d_sd   [NW+1];
	logic [W-1:0]  r_sd   [NW+1];
	logic [NW-1:0] sr_sd  [NW+1];

	logic [W-1:0]  r_nx  [NW];
	logic [NW-1:0] sr_nx [NW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_sd[0] <= 1'b0;
		end else if (advance) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_sd[0] <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			op_s1  <= op_t'(op);
			res_s1 <= res_c;
			cmp_s1 <= cmp_c;
			st_s1  <= st_c;
			neg_s1 <= lhs[W-1] ^ rhs[W-1];
			dz_s1  <= (rhs == '0);
			ma_s1  <= ma_c;
			mb_s1  <= mb_c;

			op_s2    <= op_s1;
			res_s2   <= res_s1;
			cmp_s2   <= cmp_s1;
			st_s2    <= st_s1;
			neg_s2   <= neg_s1;
			dz_s2    <= dz_s1;
			ma_s2    <= ma_s1;
			mb_s2    <= mb_s1;
			pp_hh_s2 <= ma_x[2*H-1:H] * mb_x[2*H-1:H];
			pp_hl_s2 <= ma_x[2*H-1:H] * mb_x[H-1:0];
			pp_lh_s2 <= ma_x[H-1:0] * mb_x[2*H-1:H];
			pp_ll_s2 <= ma_x[H-1:0] * mb_x[H-1:0];

			op_s3   <= op_s2;
			res_s3  <= res_s2;
			cmp_s3  <= cmp_s2;
			st_s3   <= st_s2;
			neg_s3  <= neg_s2;
			dz_s3   <= dz_s2;
			ma_s3   <= ma_s2;
			mb_s3   <= mb_s2;
			prod_s3 <= psum[PW-1:0];

			op_s4  <= op_s3;
			res_s4 <= res_s3;
			cmp_s4 <= cmp_s3;
			st_s4  <= st_s3;
			neg_s4 <= neg_s3;
			dz_s4  <= dz_s3;
			ma_s4  <= ma_s3;
			mb_s4  <= mb_s3;
			pr_s4  <= (prod_s3 + HALF) >> F;

			op_sd[0]  <= op_s4;
			res_sd[0] <= (op_s4 == OP_MUL) ? mres : res_s4;
			cmp_sd[0] <= cmp_s4;
			st_sd[0]  <= (op_s4 == OP_MUL) ? (movf ? ST_OVF : ST_OK) : st_s4;
			neg_sd[0] <= neg_s4;
			dz_sd[0]  <= dz_s4;
			d_sd[0]   <= mb_s4;
			r_sd[0]   <= '0;
			sr_sd[0]  <= {ma_s4, {(F+1){1'b0}}};
		end
	end

	for (genvar k = 0; k < NW; k++) begin : g_div
		q24a_div_step #(
			.W  (W),
			.NW (NW)
		) u_step (
			.rem      (r_sd[k]),
			.divisor  (d_sd[k]),
			.num      (sr_sd[k]),
			.rem_next (r_nx[k]),
			.num_next (sr_nx[k])
		);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_sd[k+1] <= 1'b0;
			end else if (advance) begin
				v_sd[k+1] <= v_sd[k];
			end
		end

		always_ff @(posedge clk) begin
			if (advance) begin
				op_sd[k+1]  <= op_sd[k];
				res_sd[k+1] <= res_sd[k];
				cmp_sd[k+1] <= cmp_sd[k];
				st_sd[k+1]  <= st_sd[k];
				neg_sd[k+1] <= neg_sd[k];
				dz_sd[k+1]  <= dz_sd[k];
				d_sd[k+1]   <= d_sd[k];
				r_sd[k+1]   <= r_nx[k];
				sr_sd[k+1]  <= sr_nx[k];
			end
		end
	end

	// stage 6: round quotient, stage 7: saturate and output
	logic          v_s6, v_s7;
	op_t           op_s6;
	logic [W-1:0]  res_s6, res_s7;
	logic          cmp_s6, cmp_s7;
	status_t       st_s6, st_s7;
	logic          neg_s6, dz_s6;
	logic [NW-1:0] qr_s6;

	logic          dneg, dovf;
	logic [NW-1:0] dlim;
	logic [W-1:0]  dres, dneg_v;
	logic [W-1:0]  fin_res;
	status_t       fin_st;

	always_comb begin
		dneg   = neg_s6 && (qr_s6 != '0);
		dlim   = NW'(dneg ? MINW : MAXW);
		dovf   = qr_s6 > dlim;
		dneg_v = ~qr_s6[W-1:0] + 1'b1;
		if (dovf) begin
			dres = dneg ? MINW : MAXW;
		end else begin
			dres = dneg ? dneg_v : qr_s6[W-1:0];
		end
		fin_res = res_s6;
		fin_st  = st_s6;
		if (op_s6 == OP_DIV) begin
			if (dz_s6) begin
				fin_res = neg_s6 ? MINW : MAXW;
				fin_st  = ST_DIVZ;
			end else begin
				fin_res = dres;
				fin_st  = dovf ? ST_OVF : ST_OK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (advance) begin
			v_s6 <= v_sd[NW];
			v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			op_s6  <= op_sd[NW];
			res_s6 <= res_sd[NW];
			cmp_s6 <= cmp_sd[NW];
			st_s6  <= st_sd[NW];
			neg_s6 <= neg_sd[NW];
			dz_s6  <= dz_sd[NW];
			qr_s6  <= (sr_sd[NW] + NW'(1)) >> 1;

			res_s7 <= fin_res;
			cmp_s7 <= cmp_s6;
			st_s7  <= fin_st;
		end
	end

	assign advance      = !v_s7 || !out_stall;
	assign in_stall     = !advance;
	assign out_valid    = v_s7;
	assign result       = res_s7;
	assign compare_true = cmp_s7;
	assign status       = st_s7;

endmodule

`default_nettype wire

### design/q24a_checker.sv
// ----------------------------------------------------------------------------
// q24a_checker
// Port-level checks of the fixed-point ALU, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module q24a_checker
	import q24a_pkg::*;
#(
	parameter int WORD_WIDTH = 32
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_stall,
	input logic                         out_valid,
	input logic                         out_stall,
	input logic signed [WORD_WIDTH-1:0] result,
	input logic                         compare_true,
	input logic [1:0]                   status
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result))
		else $error("output transaction dropped or changed under stall");

	a_in_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without an output stall");

	a_cmp_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && compare_true |-> status == ST_OK && result == '0)
		else $error("comparison with nonzero result or status");

	a_free_flow: assert property (@(posedge clk) disable iff (!arst_n)
		!out_stall |-> !in_stall)
		else $error("input stalled while output flows");

endmodule

bind q24_8_fixed_point_alu_top q24a_checker #(
	.WORD_WIDTH (WORD_WIDTH)
) u_q24a_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_stall     (in_stall),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.result       (result),
	.compare_true (compare_true),
	.status       (status)
);

`default_nettype wire
